// File: src/rtc_pkg.sv
// Shared types and constants for the RGB to CMYK separation block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rtc_pkg;

  localparam int PIX_W   = 8;
  localparam int GAIN_W  = 10;
  localparam int PROD_W  = PIX_W + GAIN_W;
  localparam int LANES   = 3;
  localparam int STEPS   = PIX_W;
  localparam int INDEX_W = 2;

  localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;
  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 10'd256;

  // Register indexes of the configuration port.
  localparam logic [INDEX_W-1:0] REG_CYAN    = 2'd0;
  localparam logic [INDEX_W-1:0] REG_MAGENTA = 2'd1;
  localparam logic [INDEX_W-1:0] REG_YELLOW  = 2'd2;
  localparam logic [INDEX_W-1:0] REG_BLACK   = 2'd3;

  // One lane of the divider: partial remainder and the word that shifts the
  // low dividend bits out and the quotient bits in.
  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] nq;
  } lane_t;

  // What travels along the divider row for one pixel.
  typedef struct packed {
    logic [PIX_W-1:0]        mx;
    lane_t [LANES-1:0]       lane;
  } pix_t;

endpackage

// File: src/rtc_div_cell.sv
// One step of the restoring divider row: one quotient bit for each colour lane.
// Depends on rtc_pkg for the pixel record.
`timescale 1ns / 1ps

module rtc_div_cell
  import rtc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  pix_t in_pix,
  output logic out_valid,
  output pix_t out_pix
);

  pix_t pix_next;

  always_comb begin
    logic [PIX_W:0] trial;
    pix_next.mx = in_pix.mx;
    for (int l = 0; l < LANES; l++) begin
      trial = {in_pix.lane[l].rem, in_pix.lane[l].nq[PIX_W-1]};
      if (trial >= {1'b0, in_pix.mx}) begin
        pix_next.lane[l].rem = PIX_W'(trial - {1'b0, in_pix.mx});
        pix_next.lane[l].nq  = {in_pix.lane[l].nq[PIX_W-2:0], 1'b1};
      end else begin
        pix_next.lane[l].rem = trial[PIX_W-1:0];
        pix_next.lane[l].nq  = {in_pix.lane[l].nq[PIX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix <= pix_next;
    end
  end

endmodule

// File: src/rtc_scale.sv
// Gain stage for one ink: registered product, then saturation and inversion.
// Depends on rtc_pkg for widths.
`timescale 1ns / 1ps

module rtc_scale
  import rtc_pkg::*;
(
  input  logic              clk,
  input  logic              adv_mul,
  input  logic              adv_out,
  input  logic [PIX_W-1:0]  ink,
  input  logic [GAIN_W-1:0] gain,
  output logic [PIX_W-1:0]  plane
);

  logic [PROD_W-1:0] prod;
  logic [GAIN_W-1:0] scaled;

  assign scaled = prod[PROD_W-1:PIX_W];

  always_ff @(posedge clk) begin
    if (adv_mul) begin
      prod <= PROD_W'(ink) * PROD_W'(gain);
    end
  end

  // Anything above full ink saturates, which leaves no room in the plane.
  always_ff @(posedge clk) begin
    if (adv_out) begin
      if (scaled > GAIN_W'(PIX_MAX)) begin
        plane <= '0;
      end else begin
        plane <= PIX_MAX - scaled[PIX_W-1:0];
      end
    end
  end

endmodule

// File: src/rgb_to_cmyk_separation.sv
// RGB to CMYK separation: one pixel per cycle while the output is not stalled.
// Stages: input register, eight divider cells, gain multiply, saturate and output register.
// The divider row is pipelined, and its cells each retire one quotient bit per lane per cycle unless stalled.
// Each stage holds only while the stage after it is full and stalled, so bubbles close up.
// Synchronous active-high reset empties the pipeline and sets all four gains to 1.0.
// Depends on rtc_pkg, rtc_div_cell and rtc_scale.
`timescale 1ns / 1ps

module rgb_to_cmyk_separation
  import rtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Pixel requests in.
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,   // red [7:0], green [15:8], blue [23:16]
  // Plane requests out.
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,   // cyan_plane [7:0], magenta_plane [15:8],
                                        // yellow_plane [23:16], black_plane [31:24]
  // Configuration writes.
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]  cfg_data
);

  // Gain registers, Q2.8.
  logic [GAIN_W-1:0] cyan_gain;
  logic [GAIN_W-1:0] magenta_gain;
  logic [GAIN_W-1:0] yellow_gain;
  logic [GAIN_W-1:0] black_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      cyan_gain    <= GAIN_ONE;
      magenta_gain <= GAIN_ONE;
      yellow_gain  <= GAIN_ONE;
      black_gain   <= GAIN_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CYAN:    cyan_gain    <= cfg_data;
        REG_MAGENTA: magenta_gain <= cfg_data;
        REG_YELLOW:  yellow_gain  <= cfg_data;
        REG_BLACK:   black_gain   <= cfg_data;
      endcase
    end
  end

  // Stage 0 is the input register; stages 1 to STEPS are the divider cells.
  logic [STEPS:0]   valid;
  pix_t             pix [STEPS+1];
  logic [STEPS+1:0] adv;
  logic             mul_valid;
  logic             adv_mul;
  logic             adv_out;

  // A stage may load when it is empty or when its content moves on this cycle.
  always_comb begin
    adv_out = !m_tvalid || m_tready;
    adv_mul = !mul_valid || adv_out;
    adv[STEPS+1] = adv_mul;
    for (int i = STEPS; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  assign s_tready = adv[0];

  // Front stage: find the largest channel and set up each dividend
  // (mx - channel) * 255, built as a shift and a subtract. Its upper byte is
  // below mx whenever mx is nonzero, so the divider only needs eight quotient bits.
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  pix_t             front_next;

  assign red   = s_tdata[7:0];
  assign green = s_tdata[15:8];
  assign blue  = s_tdata[23:16];

  always_comb begin
    logic [PIX_W-1:0]   mx;
    logic [PIX_W-1:0]   chan [LANES];
    logic [PIX_W-1:0]   diff;
    logic [2*PIX_W-1:0] num;
    mx = red;
    if (green > mx) begin
      mx = green;
    end
    if (blue > mx) begin
      mx = blue;
    end
    chan[0] = red;
    chan[1] = green;
    chan[2] = blue;
    front_next.mx = mx;
    for (int l = 0; l < LANES; l++) begin
      diff = mx - chan[l];
      num  = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
      front_next.lane[l].rem = num[2*PIX_W-1:PIX_W];
      front_next.lane[l].nq  = num[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv[0]) begin
      valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pix[0] <= front_next;
    end
  end

  // The divider row: each cell shifts one dividend bit in and one quotient
  // bit out per lane, and hands the pixel on to its neighbour.
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    rtc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv[k+1]),
      .in_valid  (valid[k]),
      .in_pix    (pix[k]),
      .out_valid (valid[k+1]),
      .out_pix   (pix[k+1])
    );
  end

  // A black pixel divides by zero; its colour inks are defined as none.
  logic [PIX_W-1:0] ink [LANES+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ink[l] = (pix[STEPS].mx == '0) ? '0 : pix[STEPS].lane[l].nq;
    end
    ink[LANES] = PIX_MAX - pix[STEPS].mx;
  end

  logic [GAIN_W-1:0] gain [LANES+1];
  logic [PIX_W-1:0]  plane [LANES+1];

  assign gain[0] = cyan_gain;
  assign gain[1] = magenta_gain;
  assign gain[2] = yellow_gain;
  assign gain[3] = black_gain;

  for (genvar j = 0; j <= LANES; j++) begin : g_scale
    rtc_scale u_scale (
      .clk     (clk),
      .adv_mul (adv_mul),
      .adv_out (adv_out),
      .ink     (ink[j]),
      .gain    (gain[j]),
      .plane   (plane[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (adv_mul) begin
        mul_valid <= valid[STEPS];
      end
      if (adv_out) begin
        m_tvalid <= mul_valid;
      end
    end
  end

  assign m_tdata = {plane[3], plane[2], plane[1], plane[0]};

endmodule
